FILE: design/burc_pkg.sv
// Shared constants and types for the bounded uniform range encoder.
package burc_pkg;

    // Default width of the low part when a bound is split in two
    localparam int SPLIT_BITS_DEF = 12;

    // Most byte-run beats that one input item may release
    localparam int NUM_OUT = 5;

    // Configuration port address width and register indexes
    localparam int ADDR_W = 3;
    localparam logic REG_MAIN_END = 1'b0;

    // Input kinds
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // One released byte run
    typedef struct packed {
        logic [7:0]  lead_byte;
        logic [7:0]  fill_byte;
        logic [31:0] fill_count;
    } res_t;

    // One result beat handed from the core to the output register
    typedef struct packed {
        res_t res;
        logic last_of_item;
        logic end_of_stream;
    } push_t;

endpackage

FILE: design/bounded_uniform_range_encoder_top.sv
// Top level of the bounded uniform range encoder: config port, core and output register.
//
// Input channel s_*: one beat is either an encode (s_kind 0) of s_source_pos
// against a bound taken from s_dest_pos and main_end, or a flush (s_kind 1).
// Result channel m_*: each beat is one released byte run, a lead byte then
// m_fill_count copies of m_fill_byte; m_last_of_item marks the final beat of
// an input, m_end_of_stream the final beat of a flush. An encode may give none.
// main_end is written over the APB-style port at addresses 0 to 3 (paddr[2]
// clear); the user must write it only while idle, which the block itself does
// not enforce. One item is in flight at a time; s_ready is high only between items.
// An encode whose bound is above 2^SPLIT_BITS codes a high then a low part, each
// through the shared bit-serial divider, a multiply-add step and the renormalizing
// shifts, between a setup and a done step. A bound up to 2^SPLIT_BITS codes one
// part, a bound below two none. A flush returns the coder to its reset state.
// A result beat sits in the output register while a new run is formed in a
// hold stage; if the receiver stalls, the core waits before releasing more.
// Synchronous active-low reset clears the coder, main_end and the output valid flag.
module bounded_uniform_range_encoder_top #(
    parameter int SPLIT_BITS = burc_pkg::SPLIT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [burc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [31:0]                 s_dest_pos,
    input  logic [31:0]                 s_source_pos,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_lead_byte,
    output logic [7:0]                  m_fill_byte,
    output logic [31:0]                 m_fill_count,
    output logic                        m_last_of_item,
    output logic                        m_end_of_stream
);

    logic [31:0]     main_end_reg;
    logic            out_valid_reg;
    burc_pkg::push_t out_reg;
    logic            push_valid;
    logic            push_ready;
    burc_pkg::push_t push_data;
    logic            reg_hit;

    // Register write and read-back
    assign pready  = 1'b1;
    assign reg_hit = (paddr[burc_pkg::ADDR_W-1] == burc_pkg::REG_MAIN_END);
    assign prdata  = reg_hit ? main_end_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_end_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            main_end_reg <= pwdata;
        end
    end

    burc_core #(
        .SPLIT_BITS (SPLIT_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_kind    (s_kind),
        .in_dest    (s_dest_pos),
        .in_src     (s_source_pos),
        .main_end   (main_end_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Load a new beat when the output is empty or being drained
    assign push_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push_valid && push_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (push_valid && push_ready) begin
            out_reg <= push_data;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_lead_byte     = out_reg.res.lead_byte;
    assign m_fill_byte     = out_reg.res.fill_byte;
    assign m_fill_count    = out_reg.res.fill_count;
    assign m_last_of_item  = out_reg.last_of_item;
    assign m_end_of_stream = out_reg.end_of_stream;

endmodule

FILE: design/burc_div.sv
// Iterative 32-bit restoring divider, one quotient bit per cycle.
module burc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/burc_core.sv
// Range coder sequencer: bound setup, divide, multiply-add and byte renormalization.
module burc_core #(
    parameter int SPLIT_BITS = burc_pkg::SPLIT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_kind,
    input  logic [31:0]        in_dest,
    input  logic [31:0]        in_src,
    input  logic [31:0]        main_end,
    output logic               push_valid,
    input  logic               push_ready,
    output burc_pkg::push_t    push_data
);

    localparam int VW = 32 - SPLIT_BITS;
    localparam logic [32:0] K_W = 33'd1 << SPLIT_BITS;
    localparam logic [2:0] FLUSH_SHIFTS = 3'd5;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_NORM  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic        kind_reg, kind_next;
    logic [31:0] bound_reg, bound_next;
    logic [31:0] val_reg, val_next;
    logic [VW-1:0] part_v_reg, part_v_next;
    logic [31:0] div_m_reg, div_m_next;
    logic        two_part_reg, two_part_next;
    logic        part_reg, part_next;
    logic [2:0]  shift_cnt_reg, shift_cnt_next;
    logic [2:0]  res_cnt_reg, res_cnt_next;
    logic        held_valid_reg, held_valid_next;
    burc_pkg::res_t held_reg, held_next;

    logic [32:0] low_reg, low_next;
    logic [31:0] range_reg, range_next;
    logic [7:0]  cached_reg, cached_next;
    logic [31:0] pending_reg, pending_next;

    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;

    logic [31:0] bound_sel;
    logic [31:0] v_clamp;
    logic [32:0] hm_wide;
    logic [VW+31:0] prod;
    logic        carry;
    logic        release_bytes;
    logic        emit_now;
    logic        more_shift;
    burc_pkg::res_t new_res;

    // The divisor is taken as it is being chosen, in the cycle that starts the divider
    burc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (range_reg),
        .divisor  (div_m_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Bound from destination and main end
    always_comb begin
        if (in_dest < main_end) begin
            bound_sel = (in_dest != 32'd0) ? in_dest : 32'd1;
        end else begin
            bound_sel = main_end;
        end
    end

    // Clamp source and work out the high-part bound
    assign v_clamp = (val_reg >= bound_reg) ? (bound_reg - 32'd1) : val_reg;
    assign hm_wide = ({1'b0, bound_reg} + (K_W - 33'd1)) >> SPLIT_BITS;

    // Coded part times the divided range
    assign prod = part_v_reg * range_reg;

    // One renormalizing shift and the byte run it would release
    assign carry         = low_reg[32];
    assign release_bytes = carry || (low_reg[31:0] < 32'hFF00_0000);
    assign emit_now      = release_bytes && (res_cnt_reg < 3'(burc_pkg::NUM_OUT));
    assign more_shift    = kind_reg ? (shift_cnt_reg < FLUSH_SHIFTS)
                                    : (range_reg < 32'h0100_0000);
    assign new_res.lead_byte  = cached_reg + {7'd0, carry};
    assign new_res.fill_byte  = carry ? 8'h00 : 8'hFF;
    assign new_res.fill_count = pending_reg - 32'd1;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        bound_next      = bound_reg;
        val_next        = val_reg;
        part_v_next     = part_v_reg;
        div_m_next      = div_m_reg;
        two_part_next   = two_part_reg;
        part_next       = part_reg;
        shift_cnt_next  = shift_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        low_next        = low_reg;
        range_next      = range_reg;
        cached_next     = cached_reg;
        pending_next    = pending_reg;
        div_start       = 1'b0;
        push_valid      = 1'b0;
        push_data       = '0;
        in_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next      = in_kind;
                    bound_next     = bound_sel;
                    val_next       = in_src;
                    shift_cnt_next = '0;
                    res_cnt_next   = '0;
                    part_next      = 1'b0;
                    state_next     = (in_kind == burc_pkg::KIND_FLUSH) ? ST_NORM : ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (bound_reg < 32'd2) begin
                    state_next = ST_DONE;
                end else begin
                    val_next = v_clamp;
                    if ({1'b0, bound_reg} <= K_W) begin
                        two_part_next = 1'b0;
                        div_m_next    = bound_reg;
                        part_v_next   = VW'(v_clamp[SPLIT_BITS-1:0]);
                    end else begin
                        two_part_next = 1'b1;
                        div_m_next    = hm_wide[31:0];
                        part_v_next   = v_clamp[31:SPLIT_BITS];
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    range_next = div_quo;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                low_next   = low_reg + prod[32:0];
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (more_shift) begin
                    // Stall when the held run must move out but the output is full
                    if (!(emit_now && held_valid_reg && !push_ready)) begin
                        if (emit_now) begin
                            push_valid      = held_valid_reg;
                            push_data.res   = held_reg;
                            held_next       = new_res;
                            held_valid_next = 1'b1;
                            res_cnt_next    = res_cnt_reg + 3'd1;
                        end
                        if (release_bytes) begin
                            cached_next  = low_reg[31:24];
                            pending_next = 32'd1;
                        end else if (pending_reg != 32'hFFFF_FFFF) begin
                            pending_next = pending_reg + 32'd1;
                        end
                        low_next       = {1'b0, low_reg[23:0], 8'h00};
                        shift_cnt_next = shift_cnt_reg + 3'd1;
                        if (!kind_reg) begin
                            range_next = {range_reg[23:0], 8'h00};
                        end
                    end
                end else if (!kind_reg && two_part_reg && !part_reg) begin
                    // Advance to the low part
                    part_next   = 1'b1;
                    div_m_next  = K_W[31:0];
                    part_v_next = VW'(val_reg[SPLIT_BITS-1:0]);
                    state_next  = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                push_valid             = held_valid_reg;
                push_data.res          = held_reg;
                push_data.last_of_item = 1'b1;
                push_data.end_of_stream = kind_reg;
                if (!held_valid_reg || push_ready) begin
                    held_valid_next = 1'b0;
                    if (kind_reg) begin
                        low_next     = '0;
                        range_next   = 32'hFFFF_FFFF;
                        cached_next  = '0;
                        pending_next = 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Kick the divider on entry to the divide step
        if ((state_reg != ST_DIV) && (state_next == ST_DIV)) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_valid_reg <= 1'b0;
            low_reg        <= '0;
            range_reg      <= 32'hFFFF_FFFF;
            cached_reg     <= '0;
            pending_reg    <= 32'd1;
            shift_cnt_reg  <= '0;
            res_cnt_reg    <= '0;
            part_reg       <= 1'b0;
            two_part_reg   <= 1'b0;
            kind_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            low_reg        <= low_next;
            range_reg      <= range_next;
            cached_reg     <= cached_next;
            pending_reg    <= pending_next;
            shift_cnt_reg  <= shift_cnt_next;
            res_cnt_reg    <= res_cnt_next;
            part_reg       <= part_next;
            two_part_reg   <= two_part_next;
            kind_reg       <= kind_next;
        end
        bound_reg  <= bound_next;
        val_reg    <= val_next;
        part_v_reg <= part_v_next;
        div_m_reg  <= div_m_next;
        held_reg   <= held_next;
    end

endmodule

FILE: design/burc_chk.sv
// Port-level checker for the bounded uniform range encoder, with its bind.
module burc_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_lead_byte,
    input logic [7:0]                  m_fill_byte,
    input logic [31:0]                 m_fill_count,
    input logic                        m_last_of_item,
    input logic                        m_end_of_stream
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lead_byte)
            && $stable(m_fill_byte) && $stable(m_fill_count)
            && $stable(m_last_of_item) && $stable(m_end_of_stream))
        else $error("result beat changed while stalled");

    // End of stream only on the last beat of an item
    a_eos_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_stream |-> m_last_of_item)
        else $error("end_of_stream without last_of_item");

    // Fill byte is all ones or, after a carry, zero
    a_fill_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill_byte == 8'h00 || m_fill_byte == 8'hFF))
        else $error("bad fill byte");

    // Drop ready once an item is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // Config port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind bounded_uniform_range_encoder_top burc_chk u_burc_chk (.*);
